[hw/rtl/atan2pa_pkg.sv]
package atan2pa_pkg;

   // Input sample width and the widths that follow from it.
   localparam int IN_WIDTH = 16;
   localparam int MAG_W    = IN_WIDTH;
   localparam int DEN_W    = IN_WIDTH + 1;
   localparam int REM_W    = IN_WIDTH + 2;
   localparam int REQ_W    = ((2 * IN_WIDTH + 7) / 8) * 8;

   // Output and internal fixed-point widths.
   localparam int ANGLE_W  = 16;
   localparam int RSP_W    = ((ANGLE_W + 7) / 8) * 8;
   localparam int QUO_W    = 17;
   localparam int R_W      = 16;
   localparam int SUM_W    = 34;

   // The divider develops QUO_W - 1 quotient bits after the leading one.
   localparam int DIV_STAGES = 4;
   localparam int DIV_STEPS  = (QUO_W - 1) / DIV_STAGES;

   // Polynomial coefficients in Q15 and quadrant bases in Q30.
   localparam logic signed [SUM_W-1:0] C3_Q15 = 34'sd6432;
   localparam logic signed [SUM_W-1:0] C1_Q15 = 34'sd32168;
   localparam logic signed [SUM_W-1:0] B1_Q30 = 34'sd843314857;
   localparam logic signed [SUM_W-1:0] B3_Q30 = 34'sd2529944570;
   localparam logic signed [17:0]      PI_Q13 = 18'sd25736;

   typedef struct packed {
      logic y_neg;
      logic num_neg;
      logic base_hi;
      logic den_zero;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic             q_bit;
   } div_step_type;

   // One restoring division step: shift the remainder and try to subtract.
   function automatic div_step_type div_step(input logic [REM_W-1:0] rem,
                                             input logic [DEN_W-1:0] den);
      div_step_type     res;
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] dx;
      sh = {rem[REM_W-2:0], 1'b0};
      dx = {1'b0, den};
      if (sh >= dx) begin
         res.rem   = sh - dx;
         res.q_bit = 1'b1;
      end else begin
         res.rem   = sh;
         res.q_bit = 1'b0;
      end
      return res;
   endfunction

endpackage

[hw/rtl/atan2_polynomial_approx.sv]
// Four-quadrant arctangent of a signed (y, x) sample pair.
// Input channel req_*: one transaction carries y in the low half of
// req_tdata and x in the high half. Result channel rsp_*: one transaction
// per input, angle in radians as Q2.13, limited to plus or minus pi.
// The angle comes from r = (x - |y|)/(x + |y|) (or its mirror for x < 0),
// a cubic in r and a quadrant base; x = y = 0 gives an angle near pi/2.
// The path from an accepted input to rsp_tvalid runs through one setup
// stage, four divider stages of four quotient bits each (the first also
// settles the leading bit), then rounding of r, two multiplies for r cubed,
// rounding of r cubed, the coefficient products, the sum and the output
// register. One pair is accepted in every cycle unless a stall fills every stage.
// Each stage holds its own valid bit, so while the receiver stalls the
// empty stages behind the output keep filling; req_tready drops only once
// every stage holds data. Nothing is dropped or repeated under stall.
// Reset (synchronous, active high) empties the pipeline; results in flight
// are discarded and the block is ready on the next cycle.
module atan2_polynomial_approx import atan2pa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // y_value, x_value
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // angle
);

   localparam int POST = 7;

   // Setup stage.
   logic signed [IN_WIDTH-1:0] y_val;
   logic signed [IN_WIDTH-1:0] x_val;
   logic [MAG_W-1:0]           ay;
   logic signed [IN_WIDTH+1:0] xe;
   logic signed [IN_WIDTH+1:0] aye;
   logic signed [IN_WIDTH+1:0] num;
   logic signed [IN_WIDTH+1:0] den;
   logic signed [IN_WIDTH+1:0] nm_full;

   logic             setup_valid_ff;
   logic             setup_adv;
   logic [MAG_W-1:0] setup_mag_ff, setup_mag_in;
   logic [DEN_W-1:0] setup_den_ff, setup_den_in;
   side_type         setup_side_ff, setup_side_in;

   // Divider outputs.
   logic             div_ready;
   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   side_type         div_side;

   // Post stages: r, r^2, r^3 exact, r^3 rounded, products, sum, output.
   logic [POST-1:0] valid_ff;
   logic [POST:0]   adv;

   logic [QUO_W:0]            q_sum;
   logic [R_W-1:0]            q_mag;
   logic signed [R_W-1:0]     r_ff, r_in;
   side_type                  r_side_ff;
   logic signed [31:0]        r2_ff, r2_in;
   logic signed [R_W-1:0]     r2_r_ff;
   side_type                  r2_side_ff;
   logic signed [47:0]        r3f_ff, r3f_in;
   logic signed [R_W-1:0]     r3f_r_ff;
   side_type                  r3f_side_ff;
   logic signed [47:0]        r3_round;
   logic signed [16:0]        r3_ff, r3_in;
   logic signed [R_W-1:0]     r3_r_ff;
   side_type                  r3_side_ff;
   logic signed [SUM_W-1:0]   p3_ff, p3_in;
   logic signed [SUM_W-1:0]   p1_ff, p1_in;
   side_type                  pr_side_ff;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   side_type                  sum_side_ff;
   logic signed [SUM_W-1:0]   sum_round;
   logic signed [17:0]        ang_signed;
   logic signed [ANGLE_W-1:0] ang_ff, ang_in;

   // ---------------- setup ----------------
   always_comb begin
      y_val = req_tdata[IN_WIDTH-1:0];
      x_val = req_tdata[2*IN_WIDTH-1:IN_WIDTH];
      ay    = y_val[IN_WIDTH-1] ? (~y_val + 1'b1) : y_val;
      xe    = {{2{x_val[IN_WIDTH-1]}}, x_val};
      aye   = {2'b00, ay};
      if (!x_val[IN_WIDTH-1]) begin
         num = xe - aye;
         den = xe + aye;
         setup_side_in.base_hi = 1'b0;
      end else begin
         num = xe + aye;
         den = aye - xe;
         setup_side_in.base_hi = 1'b1;
      end
      nm_full                = num[IN_WIDTH+1] ? -num : num;
      setup_mag_in           = nm_full[MAG_W-1:0];
      setup_den_in           = den[DEN_W-1:0];
      setup_side_in.y_neg    = y_val[IN_WIDTH-1];
      setup_side_in.num_neg  = num[IN_WIDTH+1];
      setup_side_in.den_zero = (den == '0);
   end

   assign setup_adv  = !setup_valid_ff || div_ready;
   assign req_tready = setup_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_valid_ff <= 1'b0;
      end else if (setup_adv) begin
         setup_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (setup_adv) begin
         setup_mag_ff  <= setup_mag_in;
         setup_den_ff  <= setup_den_in;
         setup_side_ff <= setup_side_in;
      end
   end

   // ---------------- divider ----------------
   atan2pa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_valid_ff),
      .in_ready  (div_ready),
      .in_mag    (setup_mag_ff),
      .in_den    (setup_den_ff),
      .in_side   (setup_side_ff),
      .out_valid (div_valid),
      .out_ready (adv[0]),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // ---------------- post stages ----------------
   always_comb begin
      adv[POST] = rsp_tready;
      for (int k = POST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   // The divider gives floor(num * 2^16 / den); halving it after adding one
   // rounds num * 2^15 / den to nearest with ties away from zero.
   always_comb begin
      q_sum = {1'b0, div_quo} + 1'b1;
      q_mag = q_sum[R_W:1];
      if (div_side.den_zero) begin
         r_in = {1'b1, {(R_W-1){1'b0}}};
      end else if (div_side.num_neg) begin
         r_in = ~q_mag + 1'b1;
      end else if (q_mag[R_W-1]) begin
         r_in = {1'b0, {(R_W-1){1'b1}}};
      end else begin
         r_in = q_mag;
      end
   end

   always_comb begin
      r2_in    = {{16{r_ff[R_W-1]}}, r_ff} * {{16{r_ff[R_W-1]}}, r_ff};
      r3f_in   = {{16{r2_ff[31]}}, r2_ff} * {{32{r2_r_ff[R_W-1]}}, r2_r_ff};
      // Adding half minus one for negative values rounds ties away from zero.
      r3_round = r3f_ff + 48'sd536870912 - {47'd0, r3f_ff[47]};
      r3_in    = r3_round[46:30];
      p3_in    = {{(SUM_W-17){r3_ff[16]}}, r3_ff} * C3_Q15;
      p1_in    = {{(SUM_W-R_W){r3_r_ff[R_W-1]}}, r3_r_ff} * C1_Q15;
      sum_in   = p3_ff - p1_ff + (pr_side_ff.base_hi ? B3_Q30 : B1_Q30);
   end

   always_comb begin
      sum_round  = sum_ff + 34'sd65536 - {33'd0, sum_ff[SUM_W-1]};
      ang_signed = {sum_round[SUM_W-1], sum_round[SUM_W-1:17]};
      if (sum_side_ff.y_neg) begin
         ang_signed = -ang_signed;
      end
      if (ang_signed > PI_Q13) begin
         ang_in = ANGLE_W'(PI_Q13);
      end else if (ang_signed < -PI_Q13) begin
         ang_in = ANGLE_W'(-PI_Q13);
      end else begin
         ang_in = ang_signed[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= div_valid;
         for (int k = 1; k < POST; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         r_ff      <= r_in;
         r_side_ff <= div_side;
      end
      if (adv[1]) begin
         r2_ff      <= r2_in;
         r2_r_ff    <= r_ff;
         r2_side_ff <= r_side_ff;
      end
      if (adv[2]) begin
         r3f_ff      <= r3f_in;
         r3f_r_ff    <= r2_r_ff;
         r3f_side_ff <= r2_side_ff;
      end
      if (adv[3]) begin
         r3_ff      <= r3_in;
         r3_r_ff    <= r3f_r_ff;
         r3_side_ff <= r3f_side_ff;
      end
      if (adv[4]) begin
         p3_ff      <= p3_in;
         p1_ff      <= p1_in;
         pr_side_ff <= r3_side_ff;
      end
      if (adv[5]) begin
         sum_ff      <= sum_in;
         sum_side_ff <= pr_side_ff;
      end
      if (adv[6]) begin
         ang_ff <= ang_in;
      end
   end

   assign rsp_tvalid = valid_ff[POST-1];
   assign rsp_tdata  = RSP_W'(ang_ff);

endmodule

[hw/rtl/atan2pa_div.sv]
module atan2pa_div import atan2pa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [MAG_W-1:0] in_mag,
   input  logic [DEN_W-1:0] in_den,
   input  side_type         in_side,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [QUO_W-1:0] out_quo,
   output side_type         out_side
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_src;
   logic [DIV_STAGES:0]   adv;

   logic [REM_W-1:0] rem_ff  [DIV_STAGES];
   logic [REM_W-1:0] rem_in  [DIV_STAGES];
   logic [REM_W-1:0] rem_src [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff  [DIV_STAGES];
   logic [QUO_W-1:0] quo_in  [DIV_STAGES];
   logic [QUO_W-1:0] quo_src [DIV_STAGES];
   logic [DEN_W-1:0] den_ff  [DIV_STAGES];
   logic [DEN_W-1:0] den_src [DIV_STAGES];
   side_type         side_ff [DIV_STAGES];
   side_type         side_src[DIV_STAGES];

   // A stage may load when it is empty or its content moves on.
   always_comb begin
      adv[DIV_STAGES] = out_ready;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   // The first stage also settles the leading quotient bit, which is 0 or 1
   // because the magnitude of the numerator never exceeds the denominator.
   always_comb begin
      valid_src[0] = in_valid;
      den_src[0]   = in_den;
      side_src[0]  = in_side;
      rem_src[0]   = {2'b00, in_mag};
      quo_src[0]   = '0;
      if ({2'b00, in_mag} >= {1'b0, in_den}) begin
         rem_src[0] = {2'b00, in_mag} - {1'b0, in_den};
         quo_src[0] = QUO_W'(1);
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         valid_src[k] = valid_ff[k-1];
         den_src[k]   = den_ff[k-1];
         side_src[k]  = side_ff[k-1];
         rem_src[k]   = rem_ff[k-1];
         quo_src[k]   = quo_ff[k-1];
      end
   end

   always_comb begin
      div_step_type st;
      for (int k = 0; k < DIV_STAGES; k++) begin
         rem_in[k] = rem_src[k];
         quo_in[k] = quo_src[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            st        = div_step(rem_in[k], den_src[k]);
            rem_in[k] = st.rem;
            quo_in[k] = {quo_in[k][QUO_W-2:0], st.q_bit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (adv[k]) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            den_ff[k]  <= den_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quo   = quo_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule
